@@ src/longest_prefix_match_table_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the longest prefix match table
// Concurrent checks that compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef LONGEST_PREFIX_MATCH_TABLE_ASSERT_SVH
`define LONGEST_PREFIX_MATCH_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define LPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define LPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ src/lpm_pkg.sv @@
// ----------------------------------------------------------------------------
// lpm_pkg
// Types, constants and the prefix mask function of the route table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpm_pkg;

    localparam int ADDR_W     = 32;
    localparam int LEN_W      = 6;
    localparam int IDX_OUT_W  = 6;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 48;
    localparam logic [LEN_W-1:0]  MAX_LEN   = 6'd32;
    localparam logic [ADDR_W-1:0] FULL_MASK = 32'hffff_ffff;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    // transfer moving down the chain of cells
    typedef struct packed {
        op_t               op;
        logic              full;
        logic              hit;
        logic [ADDR_W-1:0] key;
        logic [ADDR_W-1:0] best_net;
        logic [LEN_W-1:0]  best_len;
    } item_t;

    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] m;
        if (len > MAX_LEN)
        begin
            m = '0;
        end
        else
        begin
            m = ~(FULL_MASK >> len);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

@@ src/lpm_cell.sv @@
// ----------------------------------------------------------------------------
// lpm_cell
// One route slot of the table: stores a route on its insert and folds its
// route into the best match of each passing lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpm_cell #(
    parameter int CELL_INDEX = 0,
    parameter int IDX_W      = 7
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    input  wire logic                in_valid,
    input  wire lpm_pkg::item_t      in_item,
    input  wire logic [IDX_W-1:0]    in_cnt,
    input  wire logic [IDX_W-1:0]    in_best_idx,
    output logic                     out_valid,
    output lpm_pkg::item_t           out_item,
    output logic [IDX_W-1:0]         out_cnt,
    output logic [IDX_W-1:0]         out_best_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

    logic [lpm_pkg::ADDR_W-1:0] net_reg;
    logic [lpm_pkg::LEN_W-1:0]  len_reg;
    logic                       valid_reg;
    lpm_pkg::item_t             item_reg;
    lpm_pkg::item_t             item_next;
    logic [IDX_W-1:0]           cnt_reg;
    logic [IDX_W-1:0]           best_idx_reg;
    logic [IDX_W-1:0]           best_idx_next;
    logic [lpm_pkg::ADDR_W-1:0] mask;
    logic                       live;
    logic                       match;
    logic                       wr_en;

    always_comb
    begin
        mask  = lpm_pkg::prefix_mask(len_reg);
        // only slots filled before this lookup arrived take part
        live  = in_cnt > MY_IDX;
        match = (in_item.op == lpm_pkg::OP_LOOKUP) && live &&
                (len_reg <= lpm_pkg::MAX_LEN) &&
                (((in_item.key ^ net_reg) & mask) == '0);
        item_next     = in_item;
        best_idx_next = in_best_idx;
        // strictly longer wins, so the earliest slot keeps ties
        if (match && (!in_item.hit || (len_reg > in_item.best_len)))
        begin
            item_next.hit      = 1'b1;
            item_next.best_net = net_reg;
            item_next.best_len = len_reg;
            best_idx_next      = MY_IDX;
        end
        wr_en = advance && in_valid && (in_item.op == lpm_pkg::OP_INSERT) &&
                !in_item.full && (in_cnt == MY_IDX);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            net_reg <= in_item.key;
            len_reg <= in_item.best_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg     <= item_next;
            cnt_reg      <= in_cnt;
            best_idx_reg <= best_idx_next;
        end
    end

    assign out_valid    = valid_reg;
    assign out_item     = item_reg;
    assign out_cnt      = cnt_reg;
    assign out_best_idx = best_idx_reg;

endmodule

`default_nettype wire

@@ src/longest_prefix_match_table.sv @@
// ----------------------------------------------------------------------------
// longest_prefix_match_table
// IPv4 route table with longest prefix match, built as a chain of route cells.
//
// channel  dir  tdata                                tuser
// s_axis   in   key_address[31:0], route_len[37:32]  op[0]
// m_axis   out  match_index[5:0], match_network[37:6], found[0], status[1]
//               match_len[43:38]
//
// Every transfer walks the chain, one cell per cycle unless the output stalls;
// one input is taken per cycle while s_axis_tready is high.
// A stalled output freezes the whole chain; s_axis_tready drops with it.
// Reset clears the route count and the chain valid bits; route slots need no
// clearing since only slots below the count at acceptance are compared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "longest_prefix_match_table_assert.svh"

module longest_prefix_match_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [lpm_pkg::S_DATA_W-1:0]    s_axis_tdata,  // key_address, route_len
    input  wire logic [0:0]                      s_axis_tuser,  // op
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [lpm_pkg::M_DATA_W-1:0]         m_axis_tdata,  // match_index, match_network,
                                                                // match_len
    output logic [1:0]                           m_axis_tuser   // found, status
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (CNT_W > lpm_pkg::IDX_OUT_W) ? CNT_W : lpm_pkg::IDX_OUT_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             advance;
    logic             s_fire;
    logic             full;
    logic             ins_ok;
    lpm_pkg::item_t   head_item;
    logic [IDX_W-1:0] head_best_idx;

    logic             valid_chain    [0:TABLE_DEPTH];
    lpm_pkg::item_t   item_chain     [0:TABLE_DEPTH];
    logic [IDX_W-1:0] cnt_chain      [0:TABLE_DEPTH];
    logic [IDX_W-1:0] best_idx_chain [0:TABLE_DEPTH];

    assign advance       = !valid_chain[TABLE_DEPTH] || m_axis_tready;
    assign s_axis_tready = advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        full   = (lpm_pkg::op_t'(s_axis_tuser[0]) == lpm_pkg::OP_INSERT) &&
                 (count_reg == DEPTH_C);
        ins_ok = (lpm_pkg::op_t'(s_axis_tuser[0]) == lpm_pkg::OP_INSERT) &&
                 (count_reg != DEPTH_C);

        head_item.op       = lpm_pkg::op_t'(s_axis_tuser[0]);
        head_item.full     = full;
        head_item.hit      = 1'b0;
        head_item.key      = s_axis_tdata[lpm_pkg::ADDR_W-1:0];
        head_item.best_net = ins_ok ? s_axis_tdata[lpm_pkg::ADDR_W-1:0] : '0;
        head_item.best_len = ins_ok ?
            s_axis_tdata[lpm_pkg::ADDR_W +: lpm_pkg::LEN_W] : '0;
        head_best_idx      = ins_ok ? IDX_W'(count_reg) : '0;

        count_next = count_reg;
        if (s_fire && ins_ok)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign valid_chain[0]    = s_fire;
    assign item_chain[0]     = head_item;
    assign cnt_chain[0]      = IDX_W'(count_reg);
    assign best_idx_chain[0] = head_best_idx;

    for (genvar k = 0; k < TABLE_DEPTH; k++)
    begin : g_cell
        lpm_cell #(
            .CELL_INDEX (k),
            .IDX_W      (IDX_W)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .advance      (advance),
            .in_valid     (valid_chain[k]),
            .in_item      (item_chain[k]),
            .in_cnt       (cnt_chain[k]),
            .in_best_idx  (best_idx_chain[k]),
            .out_valid    (valid_chain[k+1]),
            .out_item     (item_chain[k+1]),
            .out_cnt      (cnt_chain[k+1]),
            .out_best_idx (best_idx_chain[k+1])
        );
    end

    assign m_axis_tvalid = valid_chain[TABLE_DEPTH];
    assign m_axis_tdata  = {
        (lpm_pkg::M_DATA_W - lpm_pkg::IDX_OUT_W - lpm_pkg::ADDR_W - lpm_pkg::LEN_W)'(0),
        item_chain[TABLE_DEPTH].best_len,
        item_chain[TABLE_DEPTH].best_net,
        best_idx_chain[TABLE_DEPTH][lpm_pkg::IDX_OUT_W-1:0]
    };
    assign m_axis_tuser  = {item_chain[TABLE_DEPTH].full, item_chain[TABLE_DEPTH].hit};

    `LPM_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= DEPTH_C,
        "route count above table depth")
    `LPM_ASSERT_NEXT(a_count_hold, clk, rst_n, !(s_fire && ins_ok), $stable(count_reg),
        "route count moved without a stored insert")
    `LPM_ASSERT_NOW(a_full_clean, clk, rst_n, m_axis_tvalid && m_axis_tuser[1],
        !m_axis_tuser[0] && (m_axis_tdata == '0), "rejected insert carries data")
    `LPM_ASSERT_NOW(a_hit_len, clk, rst_n, m_axis_tvalid && m_axis_tuser[0],
        item_chain[TABLE_DEPTH].best_len <= lpm_pkg::MAX_LEN,
        "match with prefix length above 32")

endmodule

`default_nettype wire
